>>> rtl/pbl_pkg.sv
`timescale 1ns / 1ps

package pbl_pkg;

   localparam int ADDR_W        = 26;
   localparam int PIX_W         = 32;
   localparam int CODE_W        = 8;
   localparam int PALETTE_DEPTH = 256;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 15;
   localparam int QUEUE_DEPTH   = 4;

   // Item kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Destination depth codes.
   localparam logic [1:0] DEPTH_1BPP  = 2'd0;
   localparam logic [1:0] DEPTH_8BPP  = 2'd1;
   localparam logic [1:0] DEPTH_16BPP = 2'd2;
   localparam logic [1:0] DEPTH_32BPP = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_DEPTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_STRIDE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_LEFT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_COLS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECT_ROWS   = 3'd5;

   // One queued operation: a palette load or a classified pixel write.
   typedef struct packed {
      logic              is_load;
      logic [CODE_W-1:0] index;
      logic [PIX_W-1:0]  value;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        bitpos;
      logic [1:0]        depth;
      logic              done;
   } pbl_entry_type;

endpackage

>>> rtl/pbl_ram.sv
`timescale 1ns / 1ps

module pbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pbl_front.sv
`timescale 1ns / 1ps

module pbl_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [pbl_pkg::CODE_W-1:0]         req_entry_index,
   input  logic [pbl_pkg::PIX_W-1:0]          req_entry_value,
   input  logic [pbl_pkg::CODE_W-1:0]         req_pixel_code,
   input  logic                               csr_valid,
   input  logic [pbl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pbl_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               q_full,
   output logic                               push_valid,
   output pbl_pkg::pbl_entry_type             push_entry
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int CMP_W = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;
   localparam int COL_W = CMP_W + 1;
   localparam int AW    = pbl_pkg::ADDR_W;

   logic [1:0]       pixel_depth_ff, pixel_depth_in;
   logic [14:0]      row_stride_ff, row_stride_in;
   logic [11:0]      rect_left_ff, rect_left_in;
   logic [11:0]      rect_top_ff, rect_top_in;
   logic [12:0]      rect_cols_ff, rect_cols_in;
   logic [12:0]      rect_rows_ff, rect_rows_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;
   logic [AW-1:0]    row_base_ff, row_base_in;
   logic [AW-1:0]    start_base_ff, start_base_in;
   logic             restart_ff, restart_in;

   logic             accept;
   logic             csr_hit;
   logic [CMP_W-1:0] cols_eff, rows_eff, col_next, row_next;
   logic             col_wrap, row_wrap;
   logic [COL_W-1:0] col;
   logic [AW-1:0]    col_offset;
   logic [26:0]      top_product;

   // The start-of-rectangle base needs a multiply, so it is settled in the
   // cycle after a register write while items are held off.
   assign req_stall = q_full | restart_ff;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      csr_hit = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            pbl_pkg::CSR_PIXEL_DEPTH, pbl_pkg::CSR_ROW_STRIDE, pbl_pkg::CSR_RECT_LEFT,
            pbl_pkg::CSR_RECT_TOP, pbl_pkg::CSR_RECT_COLS, pbl_pkg::CSR_RECT_ROWS:
               csr_hit = 1'b1;
            default: csr_hit = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (rect_cols_ff == 13'd0) begin
         cols_eff = CMP_W'(1);
      end else if (CMP_W'(rect_cols_ff) > CMP_W'(MAX_DIM)) begin
         cols_eff = CMP_W'(MAX_DIM);
      end else begin
         cols_eff = CMP_W'(rect_cols_ff);
      end
      if (rect_rows_ff == 13'd0) begin
         rows_eff = CMP_W'(1);
      end else if (CMP_W'(rect_rows_ff) > CMP_W'(MAX_DIM)) begin
         rows_eff = CMP_W'(MAX_DIM);
      end else begin
         rows_eff = CMP_W'(rect_rows_ff);
      end
   end

   assign col_next = CMP_W'(col_count_ff) + CMP_W'(1);
   assign row_next = CMP_W'(row_count_ff) + CMP_W'(1);
   assign col_wrap = col_next >= cols_eff;
   assign row_wrap = row_next >= rows_eff;
   assign col      = COL_W'(rect_left_ff) + COL_W'(col_count_ff);

   always_comb begin
      unique case (pixel_depth_ff)
         pbl_pkg::DEPTH_1BPP:  col_offset = AW'(col >> 3);
         pbl_pkg::DEPTH_8BPP:  col_offset = AW'(col);
         pbl_pkg::DEPTH_16BPP: col_offset = AW'(col) << 1;
         default:              col_offset = AW'(col) << 2;
      endcase
   end

   assign top_product = 27'(rect_top_ff) * 27'(row_stride_ff);

   always_comb begin
      push_valid              = accept;
      push_entry.is_load      = (req_type == pbl_pkg::REQ_LOAD);
      push_entry.index        = (req_type == pbl_pkg::REQ_LOAD) ? req_entry_index
                                                               : req_pixel_code;
      push_entry.value        = req_entry_value;
      push_entry.addr         = row_base_ff + col_offset;
      push_entry.bitpos       = 3'd7 - col[2:0];
      push_entry.depth        = pixel_depth_ff;
      push_entry.done         = col_wrap & row_wrap;
   end

   always_comb begin
      pixel_depth_in = pixel_depth_ff;
      row_stride_in  = row_stride_ff;
      rect_left_in   = rect_left_ff;
      rect_top_in    = rect_top_ff;
      rect_cols_in   = rect_cols_ff;
      rect_rows_in   = rect_rows_ff;
      col_count_in   = col_count_ff;
      row_count_in   = row_count_ff;
      row_base_in    = row_base_ff;
      start_base_in  = start_base_ff;
      restart_in     = 1'b0;

      if (restart_ff) begin
         start_base_in = top_product[AW-1:0];
         row_base_in   = top_product[AW-1:0];
      end

      if (accept && req_type == pbl_pkg::REQ_PIXEL) begin
         if (col_wrap) begin
            col_count_in = '0;
            if (row_wrap) begin
               row_count_in = '0;
               row_base_in  = start_base_ff;
            end else begin
               row_count_in = row_next[CNT_W-1:0];
               row_base_in  = row_base_ff + AW'(row_stride_ff);
            end
         end else begin
            col_count_in = col_next[CNT_W-1:0];
         end
      end

      if (csr_hit) begin
         unique case (csr_index)
            pbl_pkg::CSR_PIXEL_DEPTH: pixel_depth_in = csr_data[1:0];
            pbl_pkg::CSR_ROW_STRIDE:  row_stride_in  = csr_data[14:0];
            pbl_pkg::CSR_RECT_LEFT:   rect_left_in   = csr_data[11:0];
            pbl_pkg::CSR_RECT_TOP:    rect_top_in    = csr_data[11:0];
            pbl_pkg::CSR_RECT_COLS:   rect_cols_in   = csr_data[12:0];
            default:                  rect_rows_in   = csr_data[12:0];
         endcase
         col_count_in = '0;
         row_count_in = '0;
         restart_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_depth_ff <= pbl_pkg::DEPTH_8BPP;
         row_stride_ff  <= 15'd1024;
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_cols_ff   <= 13'd1;
         rect_rows_ff   <= 13'd1;
         col_count_ff   <= '0;
         row_count_ff   <= '0;
         row_base_ff    <= '0;
         start_base_ff  <= '0;
         restart_ff     <= 1'b0;
      end else begin
         pixel_depth_ff <= pixel_depth_in;
         row_stride_ff  <= row_stride_in;
         rect_left_ff   <= rect_left_in;
         rect_top_ff    <= rect_top_in;
         rect_cols_ff   <= rect_cols_in;
         rect_rows_ff   <= rect_rows_in;
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         row_base_ff    <= row_base_in;
         start_base_ff  <= start_base_in;
         restart_ff     <= restart_in;
      end
   end

endmodule

>>> rtl/pbl_queue.sv
`timescale 1ns / 1ps

module pbl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  pbl_pkg::pbl_entry_type push_entry,
   output logic                   full,
   output logic                   head_valid,
   output pbl_pkg::pbl_entry_type head_entry,
   input  logic                   pop
);

   localparam int PTR_W = $clog2(pbl_pkg::QUEUE_DEPTH);

   pbl_pkg::pbl_entry_type slots_ff [pbl_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   level_ff, level_in;

   assign full       = (level_ff == (PTR_W + 1)'(pbl_pkg::QUEUE_DEPTH));
   assign head_valid = (level_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff + (PTR_W + 1)'(push_valid) - (PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

>>> rtl/pbl_back.sv
`timescale 1ns / 1ps

module pbl_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  pbl_pkg::pbl_entry_type       head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pbl_pkg::ADDR_W-1:0]   rsp_mem_address,
   output logic [pbl_pkg::PIX_W-1:0]    rsp_write_data,
   output logic [pbl_pkg::PIX_W-1:0]    rsp_bit_mask,
   output logic                         rsp_rect_done
);

   logic                        lookup_valid_ff, lookup_valid_in;
   logic [pbl_pkg::ADDR_W-1:0]  lookup_addr_ff;
   logic [2:0]                  lookup_bitpos_ff;
   logic [1:0]                  lookup_depth_ff;
   logic                        lookup_done_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [pbl_pkg::ADDR_W-1:0]  out_addr_ff;
   logic [pbl_pkg::PIX_W-1:0]   out_data_ff, out_data_in;
   logic [pbl_pkg::PIX_W-1:0]   out_mask_ff, out_mask_in;
   logic                        out_done_ff;

   logic                        advance;
   logic                        pixel_pop;
   logic [pbl_pkg::PIX_W-1:0]   pix;

   assign advance   = lookup_valid_ff & (~out_valid_ff | ~rsp_stall);
   // Loads never wait on the output side; a pixel needs the lookup stage free.
   assign pop       = head_valid & (head_entry.is_load | ~lookup_valid_ff | advance);
   assign pixel_pop = pop & ~head_entry.is_load;

   pbl_ram #(
      .WIDTH (pbl_pkg::PIX_W),
      .DEPTH (pbl_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pop & head_entry.is_load),
      .wr_addr (head_entry.index),
      .wr_data (head_entry.value),
      .rd_en   (pixel_pop),
      .rd_addr (head_entry.index),
      .rd_data (pix)
   );

   always_comb begin
      unique case (lookup_depth_ff)
         pbl_pkg::DEPTH_1BPP: begin
            out_data_in = pbl_pkg::PIX_W'(pix[0]) << lookup_bitpos_ff;
            out_mask_in = pbl_pkg::PIX_W'(1) << lookup_bitpos_ff;
         end
         pbl_pkg::DEPTH_8BPP: begin
            out_data_in = {24'd0, pix[7:0]};
            out_mask_in = 32'h0000_00FF;
         end
         pbl_pkg::DEPTH_16BPP: begin
            out_data_in = {16'd0, pix[15:0]};
            out_mask_in = 32'h0000_FFFF;
         end
         default: begin
            out_data_in = pix;
            out_mask_in = 32'hFFFF_FFFF;
         end
      endcase
   end

   always_comb begin
      if (pixel_pop) begin
         lookup_valid_in = 1'b1;
      end else if (advance) begin
         lookup_valid_in = 1'b0;
      end else begin
         lookup_valid_in = lookup_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_pop) begin
         lookup_addr_ff   <= head_entry.addr;
         lookup_bitpos_ff <= head_entry.bitpos;
         lookup_depth_ff  <= head_entry.depth;
         lookup_done_ff   <= head_entry.done;
      end
      if (advance) begin
         out_addr_ff <= lookup_addr_ff;
         out_data_ff <= out_data_in;
         out_mask_ff <= out_mask_in;
         out_done_ff <= lookup_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         lookup_valid_ff <= lookup_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_mem_address = out_addr_ff;
   assign rsp_write_data  = out_data_ff;
   assign rsp_bit_mask    = out_mask_ff;
   assign rsp_rect_done   = out_done_ff;

endmodule

>>> rtl/palette_pixel_blit.sv
`timescale 1ns / 1ps
// An accepted pixel passes the queue, the lookup register and the output register to reach rsp.
// Throughput: one item per cycle unless req_stall holds items off; loads and pixels share the
// four-entry queue and the single palette RAM port pair, loads produce no write.
// Items are held off in the cycle after a register write while the row base multiply settles.
// Reset (synchronous, active high) restores the register defaults and empties the pipeline;
// the palette RAM is not cleared.

module palette_pixel_blit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [pbl_pkg::CODE_W-1:0]        req_entry_index,
   input  logic [pbl_pkg::PIX_W-1:0]         req_entry_value,
   input  logic [pbl_pkg::CODE_W-1:0]        req_pixel_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pbl_pkg::ADDR_W-1:0]        rsp_mem_address,
   output logic [pbl_pkg::PIX_W-1:0]         rsp_write_data,
   output logic [pbl_pkg::PIX_W-1:0]         rsp_bit_mask,
   output logic                              rsp_rect_done,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pbl_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                   q_full;
   logic                   push_valid;
   pbl_pkg::pbl_entry_type push_entry;
   logic                   head_valid;
   pbl_pkg::pbl_entry_type head_entry;
   logic                   pop;

   assign csr_ready = 1'b1;

   pbl_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_pixel_code  (req_pixel_code),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   pbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   pbl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mem_address (rsp_mem_address),
      .rsp_write_data  (rsp_write_data),
      .rsp_bit_mask    (rsp_bit_mask),
      .rsp_rect_done   (rsp_rect_done)
   );

endmodule

>>> rtl/pbl_checker.sv
`timescale 1ns / 1ps

module pbl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_type,
   input logic [pbl_pkg::CODE_W-1:0]        req_entry_index,
   input logic [pbl_pkg::PIX_W-1:0]         req_entry_value,
   input logic [pbl_pkg::CODE_W-1:0]        req_pixel_code,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [pbl_pkg::ADDR_W-1:0]        rsp_mem_address,
   input logic [pbl_pkg::PIX_W-1:0]         rsp_write_data,
   input logic [pbl_pkg::PIX_W-1:0]         rsp_bit_mask,
   input logic                              rsp_rect_done,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [pbl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [pbl_pkg::CSR_DATA_W-1:0]    csr_data
);

   // A write held back by the consumer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mem_address)
         && $stable(rsp_write_data) && $stable(rsp_bit_mask) && $stable(rsp_rect_done)))
      else $error("stalled write changed");

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("write visible straight after reset");

   // The mask is one bit in 1-bit mode or a whole byte, half-word or word.
   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot(rsp_bit_mask[7:0]) && rsp_bit_mask[31:8] == 24'd0)
         || rsp_bit_mask == 32'h0000_00FF || rsp_bit_mask == 32'h0000_FFFF
         || rsp_bit_mask == 32'hFFFF_FFFF)
      else $error("malformed write mask");

   // Data never reaches outside the mask.
   a_data_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_write_data & ~rsp_bit_mask) == 32'd0))
      else $error("write data outside mask");

   // A register write restarts the rectangle and holds off items in the cycle after it.
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index <= pbl_pkg::CSR_RECT_ROWS) |=> req_stall)
      else $error("items taken while the row base settles");

endmodule

bind palette_pixel_blit pbl_checker u_checker (.*);
